/* design/htfd_pkg.sv */
// ----------------------------------------------------------------------------
// htfd_pkg
// shared types, constants and the crc-8 byte step for the frame decoder
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned FRAME_BYTES   = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned RAW_W         = 20;
  localparam int unsigned HUM_W         = 14;
  localparam int unsigned TEMP_W        = 15;
  localparam int unsigned HUM_PROD_W    = 34;
  localparam int unsigned TEMP_PROD_W   = 35;
  localparam int unsigned CONV_SHIFT    = 20;

  localparam logic [7:0]  CRC_POLY      = 8'h31;
  localparam logic [7:0]  CRC_INIT      = 8'hFF;
  localparam logic [2:0]  LAST_POS      = 3'd6;
  localparam logic [3:0]  NIBBLE_MASK   = 4'hF;

  localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_W:0]   TEMP_OFFSET = 16'd5000;

  localparam logic RES_OK      = 1'b0;
  localparam logic RES_CRC_ERR = 1'b1;

  typedef struct packed {
    logic             code;
    logic [7:0]       status;
    logic [RAW_W-1:0] rh;
    logic [RAW_W-1:0] rt;
  } frame_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/humidity_temp_frame_decoder.sv */
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// decodes the seven-byte humidity/temperature sensor frame with crc-8 check
// ----------------------------------------------------------------------------
// usage: one frame byte per input word on the in channel, frame_start_i set on
// byte 0 (optional, the count also wraps by itself after seven bytes). after
// the seventh (crc) byte one result word comes out on the out channel.
// throughput: one input word per cycle while in_stall_o is low, including frame ends.
// path: the result word for the crc byte passes the front check, the queue,
// one multiply stage and one output stage before it shows on the out channel.
// a crc mismatch gives result_code 1, the status byte, and zero values.
// reset: byte count and crc restart, queue and pipeline empty, no output.
// out_stall_i holds the output word and the pipeline; the two-entry queue
// keeps the front taking bytes, and in_stall_o rises only when it is full.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               frame_start_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               result_code_o,
  output logic [7:0]                         sensor_status_o,
  output logic [htfd_pkg::RAW_W-1:0]         raw_humidity_o,
  output logic [htfd_pkg::RAW_W-1:0]         raw_temperature_o,
  output logic [htfd_pkg::HUM_W-1:0]         humidity_centipercent_o,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centidegrees_o
);
  import htfd_pkg::*;

  logic   push, full, q_valid, q_pop;
  frame_t push_data, q_data;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .queue_full_i  (full)
  );

  htfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (q_pop)
  );

  htfd_back u_back (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .q_valid_i                  (q_valid),
    .q_data_i                   (q_data),
    .q_pop_o                    (q_pop),
    .out_valid_o                (out_valid_o),
    .out_stall_i                (out_stall_i),
    .result_code_o              (result_code_o),
    .sensor_status_o            (sensor_status_o),
    .raw_humidity_o             (raw_humidity_o),
    .raw_temperature_o          (raw_temperature_o),
    .humidity_centipercent_o    (humidity_centipercent_o),
    .temperature_centidegrees_o (temperature_centidegrees_o)
  );

endmodule

/* design/htfd_front.sv */
// ----------------------------------------------------------------------------
// htfd_front
// byte counter, running crc and byte store; emits one frame record per frame
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            frame_start_i,
  output logic            push_o,
  output htfd_pkg::frame_t push_data_o,
  input  logic            queue_full_i
);
  import htfd_pkg::*;

  logic [2:0] pos_q, pos_d, pos_eff;
  logic [7:0] crc_q, crc_d, crc_eff;
  logic [7:0] store_q [FRAME_BYTES];
  logic       accept, is_last, crc_bad;
  logic [RAW_W-1:0] rh, rt;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign pos_eff    = frame_start_i ? 3'd0 : pos_q;
  assign crc_eff    = frame_start_i ? CRC_INIT : crc_q;
  assign is_last    = (pos_eff == LAST_POS);
  assign crc_bad    = (data_byte_i != crc_eff);

  assign rh = {store_q[1], store_q[2], store_q[3][7:4]};
  assign rt = {store_q[3][3:0] & NIBBLE_MASK, store_q[4], store_q[5]};

  always_comb begin
    push_o             = accept && is_last;
    push_data_o.code   = crc_bad ? RES_CRC_ERR : RES_OK;
    push_data_o.status = store_q[0];
    push_data_o.rh     = crc_bad ? '0 : rh;
    push_data_o.rt     = crc_bad ? '0 : rt;
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (accept) begin
      if (is_last) begin
        pos_d = 3'd0;
        crc_d = CRC_INIT;
      end else begin
        pos_d = pos_eff + 3'd1;
        crc_d = crc8_next(crc_eff, data_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
      crc_q <= CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_last) begin
      store_q[pos_eff] <= data_byte_i;
    end
  end

endmodule

/* design/htfd_queue.sv */
// ----------------------------------------------------------------------------
// htfd_queue
// short register queue of frame records between front and back
// ----------------------------------------------------------------------------
module htfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  htfd_pkg::frame_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output htfd_pkg::frame_t pop_data_o,
  input  logic             pop_i
);
  import htfd_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  frame_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* design/htfd_back.sv */
// ----------------------------------------------------------------------------
// htfd_back
// two-stage conversion pipeline: scale multiply, then shift, offset and output
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  htfd_pkg::frame_t                q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_code_o,
  output logic [7:0]                      sensor_status_o,
  output logic [htfd_pkg::RAW_W-1:0]      raw_humidity_o,
  output logic [htfd_pkg::RAW_W-1:0]      raw_temperature_o,
  output logic [htfd_pkg::HUM_W-1:0]      humidity_centipercent_o,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centidegrees_o
);
  import htfd_pkg::*;

  logic                   adv;
  logic                   s1_valid_q, out_valid_q;
  frame_t                 s1_q;
  logic [HUM_PROD_W-1:0]  hum_prod_q;
  logic [TEMP_PROD_W-1:0] temp_prod_q;
  logic [TEMP_W:0]        temp_full;

  logic                   code_q;
  logic [7:0]             status_q;
  logic [RAW_W-1:0]       rh_q, rt_q;
  logic [HUM_W-1:0]       hum_q;
  logic [TEMP_W-1:0]      temp_q;

  assign adv     = !(out_valid_q && out_stall_i);
  assign q_pop_o = q_valid_i && adv;

  assign temp_full = {1'b0, temp_prod_q[TEMP_PROD_W-1:CONV_SHIFT]} - TEMP_OFFSET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q        <= q_data_i;
      hum_prod_q  <= HUM_PROD_W'(q_data_i.rh) * HUM_PROD_W'(HUM_SCALE);
      temp_prod_q <= TEMP_PROD_W'(q_data_i.rt) * TEMP_PROD_W'(TEMP_SCALE);
      code_q      <= s1_q.code;
      status_q    <= s1_q.status;
      rh_q        <= s1_q.rh;
      rt_q        <= s1_q.rt;
      hum_q       <= (s1_q.code == RES_CRC_ERR) ? '0 : hum_prod_q[HUM_PROD_W-1:CONV_SHIFT];
      temp_q      <= (s1_q.code == RES_CRC_ERR) ? '0 : temp_full[TEMP_W-1:0];
    end
  end

  assign out_valid_o                = out_valid_q;
  assign result_code_o              = code_q;
  assign sensor_status_o            = status_q;
  assign raw_humidity_o             = rh_q;
  assign raw_temperature_o          = rt_q;
  assign humidity_centipercent_o    = hum_q;
  assign temperature_centidegrees_o = signed'(temp_q);

endmodule

/* design/htfd_checker.sv */
// ----------------------------------------------------------------------------
// htfd_checker
// port-level checks for the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
module htfd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               result_code_o,
  input logic [7:0]                         sensor_status_o,
  input logic [htfd_pkg::RAW_W-1:0]         raw_humidity_o,
  input logic [htfd_pkg::RAW_W-1:0]         raw_temperature_o,
  input logic [htfd_pkg::HUM_W-1:0]         humidity_centipercent_o,
  input logic signed [htfd_pkg::TEMP_W-1:0] temperature_centidegrees_o
);
  import htfd_pkg::*;

  // stalled output word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sensor_status_o) && $stable(result_code_o)
      && $stable(raw_humidity_o) && $stable(temperature_centidegrees_o))
    else $error("output word changed while stalled");

  // crc error word carries zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o == RES_CRC_ERR) |->
      (raw_humidity_o == '0) && (raw_temperature_o == '0)
      && (humidity_centipercent_o == '0) && (temperature_centidegrees_o == '0))
    else $error("crc error word with nonzero values");

  // good word: converted humidity agrees with raw humidity, temperature at least -5000
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o == RES_OK) |->
      (humidity_centipercent_o == HUM_W'((raw_humidity_o * 34'(HUM_SCALE)) >> CONV_SHIFT))
      && (temperature_centidegrees_o >= -15'sd5000))
    else $error("converted values inconsistent with raw values");

  // input stalls only behind an output word that is held or was just held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o) || out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk_i                      (clk_i),
  .rst_ni                     (rst_ni),
  .in_valid_i                 (in_valid_i),
  .in_stall_o                 (in_stall_o),
  .out_valid_o                (out_valid_o),
  .out_stall_i                (out_stall_i),
  .result_code_o              (result_code_o),
  .sensor_status_o            (sensor_status_o),
  .raw_humidity_o             (raw_humidity_o),
  .raw_temperature_o          (raw_temperature_o),
  .humidity_centipercent_o    (humidity_centipercent_o),
  .temperature_centidegrees_o (temperature_centidegrees_o)
);
